@@ rtl/sfb_pkg.sv @@
// ----------------------------------------------------------------------------
// sfb_pkg
// shared types, constants and codes of the scale-to-fit pixel blitter
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

  localparam int unsigned SOURCE_PIXELS_DEF = 65536;
  localparam int unsigned MAX_DIMENSION     = 4096;

  localparam int unsigned DIM_W    = 13;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned STRIDE_W = 15;
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned LAYOUT_W = 27;
  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned RGB_W    = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 27;

  // divider: dimension product over a dimension
  localparam int unsigned DIV_NW = 2 * DIM_W;
  localparam int unsigned DIV_DW = DIM_W;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH     = 3'd0,
    CFG_SRC_HEIGHT    = 3'd1,
    CFG_SCREEN_WIDTH  = 3'd2,
    CFG_SCREEN_HEIGHT = 3'd3,
    CFG_LINE_STRIDE   = 3'd4,
    CFG_BPP           = 3'd5,
    CFG_LAYOUT        = 3'd6
  } cfg_reg_t;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_RENDER = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] src_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] pic_x;
    logic [11:0] pic_y;
  } in_item_t;

  typedef struct packed {
    logic [25:0] dest_byte_offset;
    logic [31:0] pixel_word;
    logic [2:0]  byte_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FIT,
    ST_DIV_FIT,
    ST_WAIT_FIT,
    ST_GEOM,
    ST_MUL_SRC,
    ST_DIV_COL,
    ST_WAIT_COL,
    ST_DIV_ROW,
    ST_WAIT_ROW,
    ST_ADDR,
    ST_READ,
    ST_ROW_OFF,
    ST_PACK
  } state_t;

endpackage

`default_nettype wire

@@ rtl/sfb_div.sv @@
// ----------------------------------------------------------------------------
// sfb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sfb_pkg::DIV_NW-1:0] dividend,
  input  wire logic [sfb_pkg::DIV_DW-1:0] divisor,
  output logic                           done,
  output logic [sfb_pkg::DIV_NW-1:0]     quotient
);
  import sfb_pkg::*;

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   trial;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_NW-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = DIV_CW'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start && !busy_r) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/sfb_store.sv @@
// ----------------------------------------------------------------------------
// sfb_store
// source pixel memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_store #(
  parameter int unsigned DEPTH = sfb_pkg::SOURCE_PIXELS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [sfb_pkg::RGB_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic [sfb_pkg::RGB_W-1:0]     rd_data
);
  import sfb_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/scale_to_fit_pixel_blitter_top.sv @@
// ----------------------------------------------------------------------------
// scale_to_fit_pixel_blitter_top
// nearest-neighbor scale-to-fit blitter with letterbox centering
// ----------------------------------------------------------------------------
//  channel  | ports                        | beat
//  ---------+------------------------------+-------------------------------
//  input    | in_valid in_ready in_data    | load or render request
//  result   | out_valid out_ready out_data | byte offset, pixel word, count
//  config   | cfg_valid cfg_ready cfg_index| one register write
//           | cfg_data                     |
//
//  a load beat is written into the store at acceptance
//  a render beat runs from acceptance to the result register through three
//  passes of the shared bit-serial divider (fit, column, row) and the steps
//  between them; a zero source dimension ends it before any division, and
//  an empty picture, an outside request or a bad pixel size after the fit pass
//  one item is in work at a time; in_ready is high only while idle
//  a finished result sits in the output register, so the next item is taken
//  while out_ready is low; a second result waits until the first is taken
//  reset is synchronous; the store holds no reset and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module scale_to_fit_pixel_blitter_top #(
  parameter int unsigned SOURCE_PIXELS = sfb_pkg::SOURCE_PIXELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sfb_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sfb_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfb_pkg::*;

  localparam int unsigned AW = $clog2(SOURCE_PIXELS);

  // configuration registers
  logic [DIM_W-1:0]    src_w_r, src_h_r, scr_w_r, scr_h_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [BPP_W-1:0]    bpp_r;
  logic [LAYOUT_W-1:0] layout_r;

  // working registers
  state_t              state_r, state_nxt;
  logic [DIM_W-1:0]    sw_r, sh_r, xw_r, xh_r;
  logic [COORD_W-1:0]  px_r, py_r;
  logic [DIV_NW-1:0]   sx_r, sy_r;
  logic                lt_r;
  logic [DIM_W-1:0]    pw_r, ph_r;
  logic [COORD_W-1:0]  lm_r, tm_r;
  logic [DIV_NW-1:0]   colp_r, rowp_r;
  logic [DIM_W-1:0]    col_r, row_r;
  logic [DIV_NW:0]     addr_r;
  logic                inrange_r;
  logic [27:0]         rowoff_r;
  out_item_t           out_r;
  logic                out_valid_r;

  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_n, div_q;
  logic [DIV_DW-1:0]   div_d;

  logic                in_acc, out_free, geom_bad;
  logic [RGB_W-1:0]    rgb;
  logic [WORD_W-1:0]   word;
  logic [15:0]         coloff;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (32'(v) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION) : v;
  endfunction

  function automatic logic [WORD_W-1:0] place(input logic [7:0] v, input logic [8:0] lb);
    logic [4:0] off;
    logic [3:0] len;
    logic [7:0] f;
    off = lb[4:0];
    len = lb[8:5];
    f   = (len >= 4'd8) ? v : 8'(v >> (4'd8 - len));
    return WORD_W'(f) << off;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= DIM_W'(256);
      src_h_r  <= DIM_W'(256);
      scr_w_r  <= DIM_W'(800);
      scr_h_r  <= DIM_W'(480);
      stride_r <= STRIDE_W'(1600);
      bpp_r    <= BPP_W'(2);
      layout_r <= LAYOUT_W'(42044075);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:     src_w_r  <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT:    src_h_r  <= cfg_data[DIM_W-1:0];
        CFG_SCREEN_WIDTH:  scr_w_r  <= cfg_data[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: scr_h_r  <= cfg_data[DIM_W-1:0];
        CFG_LINE_STRIDE:   stride_r <= cfg_data[STRIDE_W-1:0];
        CFG_BPP:           bpp_r    <= cfg_data[BPP_W-1:0];
        CFG_LAYOUT:        layout_r <= cfg_data[LAYOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // source store: loads write straight in at acceptance
  sfb_store #(.DEPTH(SOURCE_PIXELS), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (in_acc && in_data.req_type == REQ_LOAD &&
              32'(in_data.src_index) < SOURCE_PIXELS),
    .wr_addr (AW'(in_data.src_index)),
    .wr_data ({in_data.red, in_data.green, in_data.blue}),
    .rd_en   (state_r == ST_READ),
    .rd_addr (AW'(addr_r)),
    .rd_data (rgb)
  );

  // one divider serves the fit, the column and the row
  sfb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // the fit pass picks its operands from the products directly, since the
  // orientation flag is only registered as that pass starts
  always_comb begin
    unique case (state_r)
      ST_DIV_COL: begin
        div_n = colp_r;
        div_d = pw_r;
      end
      ST_DIV_ROW: begin
        div_n = rowp_r;
        div_d = ph_r;
      end
      default: begin
        div_n = (sx_r < sy_r) ? sx_r : sy_r;
        div_d = (sx_r < sy_r) ? sw_r : sh_r;
      end
    endcase
  end

  // empty picture, request outside it, or unusable pixel size
  assign geom_bad = pw_r == '0 || ph_r == '0 ||
                    {1'b0, px_r} >= pw_r || {1'b0, py_r} >= ph_r ||
                    bpp_r < BPP_W'(2) || bpp_r > BPP_W'(4);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE:     if (in_acc && in_data.req_type == REQ_RENDER) state_nxt = ST_MUL_FIT;
      ST_MUL_FIT:  state_nxt = (sw_r == '0 || sh_r == '0) ? ST_IDLE : ST_DIV_FIT;
      ST_DIV_FIT: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT_FIT;
      end
      ST_WAIT_FIT: if (div_done) state_nxt = ST_GEOM;
      ST_GEOM:     state_nxt = geom_bad ? ST_IDLE : ST_MUL_SRC;
      ST_MUL_SRC:  state_nxt = ST_DIV_COL;
      ST_DIV_COL: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT_COL;
      end
      ST_WAIT_COL: if (div_done) state_nxt = ST_DIV_ROW;
      ST_DIV_ROW: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT_ROW;
      end
      ST_WAIT_ROW: if (div_done) state_nxt = ST_ADDR;
      ST_ADDR:     state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_ROW_OFF;
      ST_ROW_OFF:  state_nxt = ST_PACK;
      ST_PACK:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pixel packing from the word read out of the store
  always_comb begin
    logic [RGB_W-1:0] v;
    v    = inrange_r ? rgb : '0;
    word = place(v[23:16], layout_r[8:0]) |
           place(v[15:8], layout_r[17:9]) |
           place(v[7:0], layout_r[26:18]);
    if (bpp_r == BPP_W'(2)) begin
      word[31:16] = '0;
    end else if (bpp_r == BPP_W'(3)) begin
      word[31:24] = '0;
    end
  end

  assign coloff = 16'(({1'b0, lm_r} + {1'b0, px_r}) * bpp_r);

  // datapath registers, loaded as the sequencer walks through
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        sw_r <= sat_dim(src_w_r);
        sh_r <= sat_dim(src_h_r);
        xw_r <= sat_dim(scr_w_r);
        xh_r <= sat_dim(scr_h_r);
        px_r <= in_data.pic_x;
        py_r <= in_data.pic_y;
      end
      ST_MUL_FIT: begin
        sx_r <= xw_r * sh_r;
        sy_r <= xh_r * sw_r;
      end
      ST_DIV_FIT:  lt_r <= sx_r < sy_r;
      ST_WAIT_FIT: begin
        pw_r <= lt_r ? xw_r : DIM_W'(div_q);
        ph_r <= lt_r ? DIM_W'(div_q) : xh_r;
      end
      ST_GEOM: begin
        lm_r <= COORD_W'((xw_r - pw_r) >> 1);
        tm_r <= COORD_W'((xh_r - ph_r) >> 1);
      end
      ST_MUL_SRC: begin
        colp_r <= DIV_NW'(px_r * sw_r);
        rowp_r <= DIV_NW'(py_r * sh_r);
      end
      ST_WAIT_COL: col_r <= DIM_W'(div_q);
      ST_WAIT_ROW: row_r <= DIM_W'(div_q);
      ST_ADDR:     addr_r <= (DIV_NW + 1)'(row_r * sw_r) + (DIV_NW + 1)'(col_r);
      ST_READ:     inrange_r <= 32'(addr_r) < SOURCE_PIXELS;
      ST_ROW_OFF:  rowoff_r <= 28'(({1'b0, tm_r} + {1'b0, py_r}) * stride_r);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_PACK && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (state_r == ST_PACK && out_free) begin
      out_r.dest_byte_offset <= OFFSET_W'(rowoff_r + 28'(coloff));
      out_r.pixel_word       <= word;
      out_r.byte_count       <= bpp_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/sfb_checker.sv @@
// ----------------------------------------------------------------------------
// sfb_checker
// port-level checks of the blitter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire sfb_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire sfb_pkg::out_item_t out_data
);
  import sfb_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a load never produces a result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_LOAD |=> !$rose(out_valid))
    else $error("result after a load");

  // a render keeps the block busy
  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_RENDER |=> !in_ready)
    else $error("input taken during a render");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.byte_count == 3'd2 || out_data.byte_count == 3'd3 ||
                  out_data.byte_count == 3'd4)
    else $error("bad byte count");

  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_count == 3'd2 |-> out_data.pixel_word[31:16] == 16'd0)
    else $error("pixel bits above two bytes");

endmodule

bind scale_to_fit_pixel_blitter_top sfb_checker u_sfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
